/* rtl/next_valid_tuple_odometer_assert.svh */
`ifndef NEXT_VALID_TUPLE_ODOMETER_ASSERT_SVH
`define NEXT_VALID_TUPLE_ODOMETER_ASSERT_SVH

// same-cycle implication
`define NVTO_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NVTO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/nvto_pkg.sv */
package nvto_pkg;

   localparam int ARITY_DEFAULT       = 8;
   localparam int DOMAIN_SIZE_DEFAULT = 64;
   localparam int NUM_VARS            = 8;
   localparam int VAR_W               = 3;
   localparam int VAL_W               = 7;
   localparam int SLOT_W              = 6;
   localparam int CSR_IDX_W           = 4;
   localparam int CSR_DATA_W          = 64;

   localparam logic [VAL_W-1:0] UNSET_CODE = 7'd127;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic     has;
      slot_type min;
      logic     sec_ok;
      slot_type sec;
      logic     nxt_ok;
      slot_type nxt;
      logic     valid;
   } var_info_type;

   function automatic slot_type lowest_set(input logic [CSR_DATA_W-1:0] bits);
      slot_type idx;
      idx = '0;
      for (int i = CSR_DATA_W - 1; i >= 0; i--) begin
         if (bits[i]) begin
            idx = slot_type'(i);
         end
      end
      return idx;
   endfunction

endpackage

/* rtl/nvto_if.sv */
interface nvto_req_if;
   logic                                                  valid;
   logic                                                  ready;
   logic [nvto_pkg::NUM_VARS*nvto_pkg::VAL_W-1:0]          tuple_in;
   logic [nvto_pkg::NUM_VARS*nvto_pkg::VAR_W-1:0]          order_in;
   logic [nvto_pkg::NUM_VARS-1:0]                          hold_mask;

   modport source (output valid, tuple_in, order_in, hold_mask, input ready);
   modport sink (input valid, tuple_in, order_in, hold_mask, output ready);
endinterface

interface nvto_rsp_if;
   logic                                                  valid;
   logic                                                  ready;
   logic [nvto_pkg::NUM_VARS*nvto_pkg::SLOT_W-1:0]         tuple_out;
   logic                                                  found;
   logic                                                  empty_domain;

   modport source (output valid, tuple_out, found, empty_domain, input ready);
   modport sink (input valid, tuple_out, found, empty_domain, output ready);
endinterface

interface nvto_csr_if;
   logic                                                  valid;
   logic                                                  ready;
   logic [nvto_pkg::CSR_IDX_W-1:0]                         index;
   logic [nvto_pkg::CSR_DATA_W-1:0]                        data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/next_valid_tuple_odometer.sv */
// channel   dir  payload                              accepted when
// req_chan  in   tuple_in, order_in, hold_mask        valid && ready
// rsp_chan  out  tuple_out, found, empty_domain       valid && ready
// csr_chan  in   index, data                          valid && ready (always ready)
//
// one word per cycle while rsp_chan.ready does not stall the output; an accepted req reaches rsp valid through
// input register, one combinational pass (per-variable scan, per-position resolve),
// result register
// req_chan.ready drops only while both registers hold words and rsp_chan.ready is low
// synchronous reset clears the valid bits and sets every domain to all ones

`include "next_valid_tuple_odometer_assert.svh"

module next_valid_tuple_odometer #(
   parameter int ARITY       = nvto_pkg::ARITY_DEFAULT,
   parameter int DOMAIN_SIZE = nvto_pkg::DOMAIN_SIZE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   nvto_req_if.sink    req_chan,
   nvto_rsp_if.source  rsp_chan,
   nvto_csr_if.sink    csr_chan
);

   localparam int TUPLE_W = nvto_pkg::NUM_VARS * nvto_pkg::VAL_W;
   localparam int ORDER_W = nvto_pkg::NUM_VARS * nvto_pkg::VAR_W;
   localparam int OUT_W   = nvto_pkg::NUM_VARS * nvto_pkg::SLOT_W;

   logic [nvto_pkg::NUM_VARS-1:0][DOMAIN_SIZE-1:0]       domain;
   nvto_pkg::var_info_type [nvto_pkg::NUM_VARS-1:0]      info;

   logic                          s1_valid_ff, s1_valid_in;
   logic [TUPLE_W-1:0]            tuple_ff, tuple_in;
   logic [ORDER_W-1:0]            order_ff, order_in;
   logic [nvto_pkg::NUM_VARS-1:0] hold_ff, hold_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]              out_tuple_ff, out_tuple_in;
   logic                          found_ff, found_in;
   logic                          empty_ff, empty_in;

   logic [OUT_W-1:0]              res_tuple;
   logic                          res_found;
   logic                          res_empty;

   logic                          advance;
   logic                          req_accept;

   nvto_csr #(
      .DOMAIN_SIZE (DOMAIN_SIZE)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .domain   (domain)
   );

   for (genvar v = 0; v < nvto_pkg::NUM_VARS; v++) begin : g_scan
      nvto_var_scan #(
         .DOMAIN_SIZE (DOMAIN_SIZE)
      ) u_scan (
         .domain (domain[v]),
         .value  (tuple_ff[v*nvto_pkg::VAL_W +: nvto_pkg::VAL_W]),
         .info   (info[v])
      );
   end

   nvto_resolve #(
      .ARITY (ARITY)
   ) u_resolve (
      .info         (info),
      .values       (tuple_ff),
      .order        (order_ff),
      .hold         (hold_ff),
      .tuple_out    (res_tuple),
      .found        (res_found),
      .empty_domain (res_empty)
   );

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      tuple_in    = tuple_ff;
      order_in    = order_ff;
      hold_in     = hold_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_accept) begin
         s1_valid_in = 1'b1;
         tuple_in    = req_chan.tuple_in;
         order_in    = req_chan.order_in;
         hold_in     = req_chan.hold_mask;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_tuple_in = out_tuple_ff;
      found_in     = found_ff;
      empty_in     = empty_ff;
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            out_tuple_in = res_tuple;
            found_in     = res_found;
            empty_in     = res_empty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tuple_ff     <= tuple_in;
      order_ff     <= order_in;
      hold_ff      <= hold_in;
      out_tuple_ff <= out_tuple_in;
      found_ff     <= found_in;
      empty_ff     <= empty_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.tuple_out    = out_tuple_ff;
   assign rsp_chan.found        = found_ff;
   assign rsp_chan.empty_domain = empty_ff;

   `NVTO_ASSERT_NEXT(a_accept_fills, clock, reset, req_accept, s1_valid_ff, "accepted word lost")
   `NVTO_ASSERT_NEXT(a_s1_moves, clock, reset, s1_valid_ff && advance, rsp_valid_ff, "stage word dropped")
   `NVTO_ASSERT_NEXT(a_stall_keeps, clock, reset, s1_valid_ff && !advance, s1_valid_ff, "stalled word lost")
   `NVTO_ASSERT_IMP(a_ready_empty, clock, reset, !s1_valid_ff, req_chan.ready, "not ready while empty")

endmodule

/* rtl/nvto_csr.sv */
module nvto_csr #(
   parameter int DOMAIN_SIZE = nvto_pkg::DOMAIN_SIZE_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           reset,
   nvto_csr_if.sink                                       csr_chan,
   output logic [nvto_pkg::NUM_VARS-1:0][DOMAIN_SIZE-1:0] domain
);

   logic [nvto_pkg::NUM_VARS-1:0][DOMAIN_SIZE-1:0] domain_ff;
   logic [nvto_pkg::NUM_VARS-1:0][DOMAIN_SIZE-1:0] domain_in;
   logic                                           write_hit;

   assign csr_chan.ready = 1'b1;
   assign write_hit = csr_chan.valid
                      && (csr_chan.index < nvto_pkg::CSR_IDX_W'(nvto_pkg::NUM_VARS));

   always_comb begin
      domain_in = domain_ff;
      if (write_hit) begin
         domain_in[csr_chan.index[nvto_pkg::VAR_W-1:0]] = csr_chan.data[DOMAIN_SIZE-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         domain_ff <= '1;
      end else begin
         domain_ff <= domain_in;
      end
   end

   assign domain = domain_ff;

endmodule

/* rtl/nvto_var_scan.sv */
module nvto_var_scan #(
   parameter int DOMAIN_SIZE = nvto_pkg::DOMAIN_SIZE_DEFAULT
) (
   input  logic [DOMAIN_SIZE-1:0]         domain,
   input  logic [nvto_pkg::VAL_W-1:0]     value,
   output nvto_pkg::var_info_type         info
);

   logic [nvto_pkg::CSR_DATA_W-1:0] dom_w;
   logic [nvto_pkg::CSR_DATA_W-1:0] rest_w;
   logic [nvto_pkg::CSR_DATA_W-1:0] above_w;
   logic                            in_range;
   logic                            is_unset;

   assign dom_w    = nvto_pkg::CSR_DATA_W'(domain);
   assign rest_w   = dom_w & (dom_w - nvto_pkg::CSR_DATA_W'(1));
   assign in_range = value < nvto_pkg::VAL_W'(DOMAIN_SIZE);
   assign is_unset = value == nvto_pkg::UNSET_CODE;

   // domain values strictly above the current one
   always_comb begin
      for (int i = 0; i < nvto_pkg::CSR_DATA_W; i++) begin
         above_w[i] = dom_w[i] && (nvto_pkg::VAL_W'(i) > value);
      end
   end

   always_comb begin
      info.has    = |dom_w;
      info.min    = nvto_pkg::lowest_set(dom_w);
      info.sec_ok = |rest_w;
      info.sec    = nvto_pkg::lowest_set(rest_w);
      info.nxt_ok = is_unset ? (|dom_w) : (|above_w);
      info.nxt    = is_unset ? nvto_pkg::lowest_set(dom_w) : nvto_pkg::lowest_set(above_w);
      info.valid  = in_range && dom_w[value[nvto_pkg::SLOT_W-1:0]];
   end

endmodule

/* rtl/nvto_resolve.sv */
module nvto_resolve #(
   parameter int ARITY = nvto_pkg::ARITY_DEFAULT
) (
   input  nvto_pkg::var_info_type [nvto_pkg::NUM_VARS-1:0]  info,
   input  logic [nvto_pkg::NUM_VARS*nvto_pkg::VAL_W-1:0]    values,
   input  logic [nvto_pkg::NUM_VARS*nvto_pkg::VAR_W-1:0]    order,
   input  logic [nvto_pkg::NUM_VARS-1:0]                    hold,
   output logic [nvto_pkg::NUM_VARS*nvto_pkg::SLOT_W-1:0]   tuple_out,
   output logic                                            found,
   output logic                                            empty_domain
);

   logic [ARITY-1:0][nvto_pkg::VAR_W-1:0] pos_var;
   nvto_pkg::slot_type [ARITY-1:0]        pos_next;
   logic [ARITY-1:0]                      seen;
   logic [ARITY-1:0]                      held;
   logic [ARITY-1:0]                      invalid;
   logic [ARITY-1:0]                      at_or_above;
   logic [ARITY-1:0]                      cand;
   logic [ARITY-1:0]                      stop_hot;
   logic [ARITY-1:0]                      wrap;
   logic [ARITY-1:0]                      wrap_empty;

   // per order position: variable, earlier occurrence, next value
   always_comb begin
      for (int q = 0; q < ARITY; q++) begin
         pos_var[q] = order[q*nvto_pkg::VAR_W +: nvto_pkg::VAR_W];
      end
      for (int q = 0; q < ARITY; q++) begin
         seen[q] = 1'b0;
         for (int r = 0; r < q; r++) begin
            seen[q] = seen[q] | (pos_var[r] == pos_var[q]);
         end
         held[q]     = hold[pos_var[q]];
         invalid[q]  = !info[pos_var[q]].valid;
         pos_next[q] = seen[q] ? info[pos_var[q]].sec : info[pos_var[q]].nxt;
      end
   end

   // first invalid position from the top, then first position that absorbs the carry
   always_comb begin
      logic later_bad;
      logic prior;
      later_bad = 1'b0;
      for (int q = ARITY - 1; q >= 0; q--) begin
         at_or_above[q] = !later_bad;
         later_bad      = later_bad | invalid[q];
      end
      prior = 1'b0;
      for (int q = 0; q < ARITY; q++) begin
         cand[q]       = at_or_above[q] && !held[q]
                         && (seen[q] ? info[pos_var[q]].sec_ok : info[pos_var[q]].nxt_ok);
         stop_hot[q]   = cand[q] && !prior;
         wrap[q]       = !prior && !cand[q] && !held[q];
         wrap_empty[q] = wrap[q] && !info[pos_var[q]].has;
         prior         = prior | cand[q];
      end
      found        = prior;
      empty_domain = |wrap_empty;
   end

   always_comb begin
      logic               set_next;
      logic               set_min;
      nvto_pkg::slot_type next_val;
      logic [nvto_pkg::VAL_W-1:0] orig;
      for (int v = 0; v < nvto_pkg::NUM_VARS; v++) begin
         set_next = 1'b0;
         set_min  = 1'b0;
         next_val = '0;
         orig     = values[v*nvto_pkg::VAL_W +: nvto_pkg::VAL_W];
         for (int q = 0; q < ARITY; q++) begin
            if (pos_var[q] == nvto_pkg::VAR_W'(v)) begin
               if (stop_hot[q]) begin
                  set_next = 1'b1;
                  next_val = pos_next[q];
               end
               if (wrap[q]) begin
                  set_min = 1'b1;
               end
            end
         end
         if (set_next) begin
            tuple_out[v*nvto_pkg::SLOT_W +: nvto_pkg::SLOT_W] = next_val;
         end else if (set_min) begin
            tuple_out[v*nvto_pkg::SLOT_W +: nvto_pkg::SLOT_W] = info[v].min;
         end else if (orig[nvto_pkg::VAL_W-1]) begin
            tuple_out[v*nvto_pkg::SLOT_W +: nvto_pkg::SLOT_W] = '0;
         end else begin
            tuple_out[v*nvto_pkg::SLOT_W +: nvto_pkg::SLOT_W] = orig[nvto_pkg::SLOT_W-1:0];
         end
      end
   end

endmodule
